[hw/rtl/trs_model_matrix_compose_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the model matrix composer
// Shorthand for clocked assertions that are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TRS_MODEL_MATRIX_COMPOSE_CORE_ASSERT_SVH
`define TRS_MODEL_MATRIX_COMPOSE_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TRSMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TRSMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/trsmc_pkg.sv]
// ----------------------------------------------------------------------------
// Model matrix composer package
// Types, constants and the rotation step table shared by the composer files.
// ----------------------------------------------------------------------------
package trsmc_pkg;

  localparam int NODE_COUNT = 256;
  localparam int NodeW      = $clog2(NODE_COUNT);
  localparam int MatWords   = 12;
  localparam int MemDepth   = NODE_COUNT * MatWords;
  localparam int MemAw      = $clog2(MemDepth);

  localparam logic [3:0] WordLast = 4'(MatWords - 1);
  localparam logic [3:0] ReadLast = 4'(MatWords);
  localparam logic [1:0] RowLast  = 2'd2;
  localparam logic [1:0] ColLast  = 2'd3;
  localparam logic [1:0] KLast    = 2'd2;

  localparam logic [33:0] DegFull    = 34'd23592960;
  localparam logic [33:0] DegQuarter = 34'd5898240;
  localparam logic [33:0] DegHalf    = DegQuarter * 34'd2;
  localparam logic [33:0] Deg3Q      = DegQuarter * 34'd3;
  localparam logic [33:0] DegEighth  = 34'd2949120;
  localparam logic [33:0] AngOffset  = DegFull * 34'd92;

  localparam logic [63:0] RadK   = 64'd1228166276394;
  localparam logic [31:0] RadKHi = 32'(RadK >> 20);
  localparam logic [31:0] RadKLo = 32'(RadK & 64'hFFFFF);
  localparam logic [63:0] OneQ30  = 64'd1073741824;
  localparam logic [63:0] HalfQ30 = 64'd536870912;

  localparam int NumTerms = 11;
  localparam logic [3:0] LastSineTerm = 4'd4;
  localparam logic [3:0] LastTerm     = 4'(NumTerms - 1);
  localparam logic [7:0] TERM_DIV [NumTerms] = '{
    8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
    8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };
  localparam logic [31:0] TERM_RECIP [NumTerms] = '{
    32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd72),
    32'(64'd4294967296 / 64'd42),  32'(64'd4294967296 / 64'd20),
    32'(64'd4294967296 / 64'd6),   32'(64'd4294967296 / 64'd132),
    32'(64'd4294967296 / 64'd90),  32'(64'd4294967296 / 64'd56),
    32'(64'd4294967296 / 64'd30),  32'(64'd4294967296 / 64'd12),
    32'(64'd4294967296 / 64'd2)
  };

  localparam logic [2:0] SRC_SX = 3'd0;
  localparam logic [2:0] SRC_CX = 3'd1;
  localparam logic [2:0] SRC_SY = 3'd2;
  localparam logic [2:0] SRC_CY = 3'd3;
  localparam logic [2:0] SRC_SZ = 3'd4;
  localparam logic [2:0] SRC_CZ = 3'd5;
  localparam logic [2:0] SRC_A  = 3'd6;
  localparam logic [2:0] SRC_B  = 3'd7;

  localparam logic [3:0] RI_00 = 4'd0;
  localparam logic [3:0] RI_01 = 4'd1;
  localparam logic [3:0] RI_02 = 4'd2;
  localparam logic [3:0] RI_10 = 4'd3;
  localparam logic [3:0] RI_11 = 4'd4;
  localparam logic [3:0] RI_12 = 4'd5;
  localparam logic [3:0] RI_20 = 4'd6;
  localparam logic [3:0] RI_21 = 4'd7;
  localparam logic [3:0] RI_22 = 4'd8;
  localparam logic [3:0] RI_A  = 4'd9;
  localparam logic [3:0] RI_B  = 4'd10;
  localparam int RegCount = 11;
  localparam logic [3:0] RStepLast = 4'd13;

  typedef struct packed {
    logic [7:0]         node_index;
    logic [7:0]         parent_index;
    logic               has_parent;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } req_t;

  typedef struct packed {
    logic [7:0]         out_node;
    logic [1:0]         row_number;
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic signed [31:0] elem_3;
    logic               last_row;
  } res_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] sin_q30;
    logic signed [31:0] cos_q30;
  } sc_out_t;

  typedef enum logic [1:0] {RM_SET, RM_NEG, RM_ADD} rmode_t;

  typedef struct packed {
    logic [2:0] sa;
    logic [2:0] sb;
    logic [3:0] dst;
    rmode_t     mode;
  } rop_t;

  typedef enum logic [4:0] {
    SC_IDLE, SC_REDUCE, SC_FOLD, SC_X1, SC_X2, SC_X3, SC_SQ, SC_SQR,
    SC_T1, SC_T2, SC_T3, SC_T4, SC_T5, SC_S1, SC_S2, SC_DONE
  } sc_state_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ASTART, ST_AWAIT, ST_RMUL, ST_RWB, ST_LMUL, ST_LWB,
    ST_PREAD, ST_PMUL, ST_PWB, ST_WRITE
  } state_t;

  function automatic rop_t r_step(input logic [3:0] s);
    rop_t op;
    case (s)
      4'd0:    op = '{SRC_SY, SRC_SX, RI_A,  RM_SET};
      4'd1:    op = '{SRC_CY, SRC_SX, RI_B,  RM_SET};
      4'd2:    op = '{SRC_CY, SRC_CZ, RI_00, RM_SET};
      4'd3:    op = '{SRC_A,  SRC_SZ, RI_00, RM_ADD};
      4'd4:    op = '{SRC_CY, SRC_SZ, RI_01, RM_NEG};
      4'd5:    op = '{SRC_A,  SRC_CZ, RI_01, RM_ADD};
      4'd6:    op = '{SRC_SY, SRC_CX, RI_02, RM_SET};
      4'd7:    op = '{SRC_CX, SRC_SZ, RI_10, RM_SET};
      4'd8:    op = '{SRC_CX, SRC_CZ, RI_11, RM_SET};
      4'd9:    op = '{SRC_SY, SRC_CZ, RI_20, RM_NEG};
      4'd10:   op = '{SRC_B,  SRC_SZ, RI_20, RM_ADD};
      4'd11:   op = '{SRC_SY, SRC_SZ, RI_21, RM_SET};
      4'd12:   op = '{SRC_B,  SRC_CZ, RI_21, RM_ADD};
      4'd13:   op = '{SRC_CY, SRC_CX, RI_22, RM_SET};
      default: op = '{SRC_SX, SRC_SX, RI_A,  RM_SET};
    endcase
    return op;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

endpackage

[hw/rtl/trsmc_sincos.sv]
// ----------------------------------------------------------------------------
// Sine and cosine of an angle in degrees
// Reduces a Q16.16 angle to one octant and evaluates Horner series in Q2.30
// on one shared multiplier.
// ----------------------------------------------------------------------------
module trsmc_sincos
  import trsmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [31:0] angle,
  output sc_out_t            sc
);

  sc_state_t   state, state_next;
  logic [33:0] r;
  logic [2:0]  k;
  logic [1:0]  quad;
  logic        swap;
  logic [21:0] red;
  logic [63:0] xh, prod;
  logic [31:0] x, x2, t, v, q0, sn, mul_a, mul_b, ps, pc;
  logic [39:0] qd;
  logic [3:0]  term;
  logic [33:0] red_step;
  logic [1:0]  fold_q;
  logic [33:0] fold_rem;

  assign red_step = DegFull << k;

  always_comb begin
    if (r >= Deg3Q) begin
      fold_q = 2'd3;
      fold_rem = r - Deg3Q;
    end else if (r >= DegHalf) begin
      fold_q = 2'd2;
      fold_rem = r - DegHalf;
    end else if (r >= DegQuarter) begin
      fold_q = 2'd1;
      fold_rem = r - DegQuarter;
    end else begin
      fold_q = 2'd0;
      fold_rem = r;
    end
  end

  always_comb begin
    case (state)
      SC_X1: begin
        mul_a = 32'(red);
        mul_b = RadKHi;
      end
      SC_X2: begin
        mul_a = 32'(red);
        mul_b = RadKLo;
      end
      SC_SQ: begin
        mul_a = x;
        mul_b = x;
      end
      SC_T1: begin
        mul_a = x2;
        mul_b = t;
      end
      SC_T3: begin
        mul_a = v;
        mul_b = TERM_RECIP[term];
      end
      SC_S1: begin
        mul_a = x;
        mul_b = t;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      SC_IDLE:   if (go) state_next = SC_REDUCE;
      SC_REDUCE: if (k == 3'd0) state_next = SC_FOLD;
      SC_FOLD:   state_next = SC_X1;
      SC_X1:     state_next = SC_X2;
      SC_X2:     state_next = SC_X3;
      SC_X3:     state_next = SC_SQ;
      SC_SQ:     state_next = SC_SQR;
      SC_SQR:    state_next = SC_T1;
      SC_T1:     state_next = SC_T2;
      SC_T2:     state_next = SC_T3;
      SC_T3:     state_next = SC_T4;
      SC_T4:     state_next = SC_T5;
      SC_T5: begin
        if (term == LastSineTerm) begin
          state_next = SC_S1;
        end else if (term == LastTerm) begin
          state_next = SC_DONE;
        end else begin
          state_next = SC_T1;
        end
      end
      SC_S1:     state_next = SC_S2;
      SC_S2:     state_next = SC_T1;
      SC_DONE:   state_next = SC_IDLE;
      default:   state_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      SC_IDLE: begin
        if (go) begin
          r <= {{2{angle[31]}}, angle} + AngOffset;
          k <= 3'd7;
        end
      end
      SC_REDUCE: begin
        if (r >= red_step) begin
          r <= r - red_step;
        end
        k <= k - 3'd1;
      end
      SC_FOLD: begin
        quad <= fold_q;
        swap <= fold_rem > DegEighth;
        red  <= (fold_rem > DegEighth) ? 22'(DegQuarter - fold_rem) : 22'(fold_rem);
      end
      SC_X2: xh <= prod;
      SC_X3: x <= 32'(((xh << 20) + prod) >> 32);
      SC_SQR: begin
        x2   <= 32'((prod + HalfQ30) >> 30);
        t    <= 32'(OneQ30);
        term <= 4'd0;
      end
      SC_T2: v <= 32'((prod + HalfQ30) >> 30);
      SC_T4: begin
        q0 <= prod[63:32];
        qd <= prod[63:32] * TERM_DIV[term];
      end
      SC_T5: begin
        t <= 32'(OneQ30) - (q0 + 32'((40'(v) - qd) >= 40'(TERM_DIV[term])));
        term <= term + 4'd1;
      end
      SC_S2: begin
        sn <= 32'((prod + HalfQ30) >> 30);
        t  <= 32'(OneQ30);
      end
      default: ;
    endcase
  end

  always_comb begin
    ps = swap ? t : sn;
    pc = swap ? sn : t;
    sc.done = (state == SC_DONE);
    case (quad)
      2'd0: begin
        sc.sin_q30 = $signed(ps);
        sc.cos_q30 = $signed(pc);
      end
      2'd1: begin
        sc.sin_q30 = $signed(pc);
        sc.cos_q30 = -$signed(ps);
      end
      2'd2: begin
        sc.sin_q30 = -$signed(ps);
        sc.cos_q30 = -$signed(pc);
      end
      default: begin
        sc.sin_q30 = -$signed(pc);
        sc.cos_q30 = $signed(ps);
      end
    endcase
  end

endmodule

[hw/rtl/trs_model_matrix_compose_core.sv]
// ----------------------------------------------------------------------------
// Model matrix composer
// Builds T * Ry * Rx * Rz * S for one node, premultiplies the stored parent
// matrix when asked, stores the 3x4 result and emits it row by row.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It names a node, a
// parent and whether the parent is used, and carries position, Euler angles
// in degrees and scale, all signed Q16.16.
// Three result rows follow, each shown on result for one cycle with strobe
// high, rows 0, 1 and 2 in order; last_row marks row 2. The receiver
// takes each row at the clock edge that ends its cycle.
// The next request is taken once busy falls. Most of the time goes to the
// sine and cosine unit, which runs once per angle and evaluates a sine and a
// cosine series on its own multiplier each time, and to the main multiplier,
// which takes a multiply state and a write-back state for each rotation,
// scale and parent product.
// The matrices live in a 3072-word store with one write and one read port;
// a parent is read in full before the node is written back.
// Reset returns the sequencer to idle and clears the strobe; the store is not
// cleared, and a parent that was never written reads as undefined.
// ----------------------------------------------------------------------------
`include "trs_model_matrix_compose_core_assert.svh"

module trs_model_matrix_compose_core
  import trsmc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic strobe,
  output res_t result
);

  state_t             state, state_next;
  req_t               req;
  logic [1:0]         aidx;
  logic               sc_go;
  logic signed [31:0] sc_angle;
  sc_out_t            sc;
  logic signed [31:0] trig [6];
  logic signed [33:0] rr [RegCount];
  logic signed [33:0] srcv [8];
  logic signed [31:0] lm [3][4];
  logic signed [31:0] pm [3][4];
  logic signed [31:0] res [3][4];
  logic signed [31:0] rowv [4];
  logic [3:0]         cnt, ridx, lidx;
  logic [1:0]         li, lj, pi, pj, pk;
  logic signed [49:0] acc, acc_sum;
  logic signed [33:0] opa, opb;
  logic signed [31:0] scl;
  logic signed [67:0] prod, rnd30, rnd16;
  rop_t               rop;
  logic [31:0]        mem [MemDepth];
  logic [31:0]        mem_rdata, mem_wdata;
  logic [MemAw-1:0]   pbase, nbase, mem_raddr, mem_waddr;
  logic               mem_we;
  logic               strobe_r;
  res_t               result_r;

  trsmc_sincos u_sincos (
    .clk   (clk),
    .rst   (rst),
    .go    (sc_go),
    .angle (sc_angle),
    .sc    (sc)
  );

  always_comb begin
    case (aidx)
      2'd0:    sc_angle = req.angle_x;
      2'd1:    sc_angle = req.angle_y;
      default: sc_angle = req.angle_z;
    endcase
    case (lj)
      2'd0:    scl = req.scale_x;
      2'd1:    scl = req.scale_y;
      default: scl = req.scale_z;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      srcv[i] = 34'(trig[i]);
    end
    srcv[SRC_A] = rr[RI_A];
    srcv[SRC_B] = rr[RI_B];
    rop   = r_step(cnt);
    lidx  = {2'b0, li} + {2'b0, li} + {2'b0, li} + {2'b0, lj};
    ridx  = cnt - 4'd1;
    rnd30 = (prod + 68'sd536870912) >>> 30;
    rnd16 = (prod + 68'sd32768) >>> 16;
    acc_sum = acc + 50'(rnd16)
            + (((pj == ColLast) && (pk == KLast)) ? 50'(pm[pi][3]) : 50'sd0);
    for (int j = 0; j < 4; j++) begin
      rowv[j] = req.has_parent ? res[cnt[3:2]][j] : lm[cnt[3:2]][j];
    end
    pbase = (MemAw'(req.parent_index[NodeW-1:0]) << 3)
          + (MemAw'(req.parent_index[NodeW-1:0]) << 2);
    nbase = (MemAw'(req.node_index[NodeW-1:0]) << 3)
          + (MemAw'(req.node_index[NodeW-1:0]) << 2);
    mem_raddr = pbase + MemAw'(cnt);
    mem_waddr = nbase + MemAw'(cnt);
    mem_wdata = rowv[cnt[1:0]];
  end

  always_comb begin
    case (state)
      ST_RMUL: begin
        opa = srcv[rop.sa];
        opb = srcv[rop.sb];
      end
      ST_LMUL: begin
        opa = rr[lidx];
        opb = 34'(scl);
      end
      ST_PMUL: begin
        opa = 34'(pm[pi][pk]);
        opb = 34'(lm[pk][pj]);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_ASTART;
      ST_ASTART: state_next = ST_AWAIT;
      ST_AWAIT: begin
        if (sc.done) begin
          state_next = (aidx == 2'd2) ? ST_RMUL : ST_ASTART;
        end
      end
      ST_RMUL:   state_next = ST_RWB;
      ST_RWB:    state_next = (cnt == RStepLast) ? ST_LMUL : ST_RMUL;
      ST_LMUL:   state_next = ST_LWB;
      ST_LWB: begin
        if ((li == RowLast) && (lj == KLast)) begin
          state_next = req.has_parent ? ST_PREAD : ST_WRITE;
        end else begin
          state_next = ST_LMUL;
        end
      end
      ST_PREAD:  if (cnt == ReadLast) state_next = ST_PMUL;
      ST_PMUL:   state_next = ST_PWB;
      ST_PWB: begin
        if ((pk == KLast) && (pi == RowLast) && (pj == ColLast)) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_PMUL;
        end
      end
      ST_WRITE:  if (cnt == WordLast) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != ST_IDLE);
    sc_go  = (state == ST_ASTART);
    mem_we = (state == ST_WRITE);
    strobe = strobe_r;
    result = result_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state    <= state_next;
      strobe_r <= (state == ST_WRITE) && (cnt[1:0] == ColLast);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    case (state)
      ST_IDLE: begin
        if (start) begin
          req      <= request;
          aidx     <= 2'd0;
          lm[0][3] <= request.pos_x;
          lm[1][3] <= request.pos_y;
          lm[2][3] <= request.pos_z;
        end
      end
      ST_AWAIT: begin
        if (sc.done) begin
          trig[{aidx, 1'b0}] <= sc.sin_q30;
          trig[{aidx, 1'b1}] <= sc.cos_q30;
          aidx <= aidx + 2'd1;
          cnt  <= 4'd0;
        end
      end
      ST_RMUL: rr[RI_12] <= -34'(trig[SRC_SX]);
      ST_RWB: begin
        case (rop.mode)
          RM_SET:  rr[rop.dst] <= 34'(rnd30);
          RM_NEG:  rr[rop.dst] <= -34'(rnd30);
          RM_ADD:  rr[rop.dst] <= rr[rop.dst] + 34'(rnd30);
          default: rr[rop.dst] <= 34'(rnd30);
        endcase
        cnt <= cnt + 4'd1;
        li  <= 2'd0;
        lj  <= 2'd0;
      end
      ST_LWB: begin
        lm[li][lj] <= sat32(rnd30);
        if (lj == KLast) begin
          lj <= 2'd0;
          li <= li + 2'd1;
        end else begin
          lj <= lj + 2'd1;
        end
        cnt <= 4'd0;
      end
      ST_PREAD: begin
        if (cnt != 4'd0) begin
          pm[ridx[3:2]][ridx[1:0]] <= mem_rdata;
        end
        cnt <= cnt + 4'd1;
        pi  <= 2'd0;
        pj  <= 2'd0;
        pk  <= 2'd0;
        acc <= '0;
      end
      ST_PWB: begin
        if (pk == KLast) begin
          res[pi][pj] <= sat32(68'(acc_sum));
          acc <= '0;
          pk  <= 2'd0;
          if (pj == ColLast) begin
            pj <= 2'd0;
            pi <= pi + 2'd1;
          end else begin
            pj <= pj + 2'd1;
          end
        end else begin
          acc <= acc_sum;
          pk  <= pk + 2'd1;
        end
        cnt <= 4'd0;
      end
      ST_WRITE: begin
        cnt <= cnt + 4'd1;
        if (cnt[1:0] == ColLast) begin
          result_r.out_node   <= req.node_index;
          result_r.row_number <= cnt[3:2];
          result_r.elem_0     <= rowv[0];
          result_r.elem_1     <= rowv[1];
          result_r.elem_2     <= rowv[2];
          result_r.elem_3     <= rowv[3];
          result_r.last_row   <= (cnt[3:2] == RowLast);
        end
      end
      default: ;
    endcase
  end

  `TRSMC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "Accepted request did not raise busy.")
  `TRSMC_ASSERT_NEXT(a_row_gap, strobe, !strobe, "Result rows were issued back to back.")
  `TRSMC_ASSERT_NOW(a_last_row, strobe && result.last_row, result.row_number == RowLast, "Last row flag on a row other than two.")

endmodule
